### hw/rtl/ogi_pkg.sv
package ogi_pkg;

  // Grid geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CNT_W      = $clog2(MAX_HEIGHT + 1);

  // Field widths
  localparam int ACTION_W   = 2;
  localparam int COORD_W    = 8;
  localparam int CHAN_W     = 8;
  localparam int BS_W       = 5;
  localparam int SIZE_W     = 9;
  localparam int RADIUS_W   = 8;
  localparam int BLK_W      = COORD_W + BS_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INFLATE_RADIUS = 2'd2;

  localparam logic [SIZE_W-1:0]   RST_MAP_WIDTH      = 9'd256;
  localparam logic [SIZE_W-1:0]   RST_MAP_HEIGHT     = 9'd256;
  localparam logic [RADIUS_W-1:0] RST_INFLATE_RADIUS = 8'd4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_INFLATE = 2'd1,
    ACT_QCELL   = 2'd2,
    ACT_QBLOCK  = 2'd3
  } action_t;

  // One step of the column window counters, plus the row write it feeds
  typedef struct packed {
    logic             add;
    logic             sub;
    logic             wr;
    logic [ROW_W-1:0] row;
  } vstep_t;

endpackage

### hw/rtl/ogi_cmd_if.sv
interface ogi_cmd_if;
  import ogi_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [COORD_W-1:0]  cell_x;
  logic [COORD_W-1:0]  cell_y;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;
  logic [BS_W-1:0]     block_size;

  modport source (output valid, action, cell_x, cell_y, red, green, blue, block_size,
                  input ready);
  modport sink   (input valid, action, cell_x, cell_y, red, green, blue, block_size,
                  output ready);
endinterface

### hw/rtl/ogi_res_if.sv
interface ogi_res_if;
  logic valid;
  logic ready;
  logic occupied;
  logic done_res;

  modport source (output valid, occupied, done_res, input ready);
  modport sink   (input valid, occupied, done_res, output ready);
endinterface

### hw/rtl/occupancy_grid_obstacle_inflate.sv
// A load off the map goes straight to the result without touching the memories;
// a block query with block_size 0 skips the block walk.
// One item in flight; the horizontal pass runs r shift steps per row and the
// vertical pass one row per cycle through the work memory's two read ports.
// Synchronous reset; afterwards a clearing pass writes all 256 rows of both
// memories, one row a cycle, with cmd.ready low until the pass ends.
module occupancy_grid_obstacle_inflate (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ogi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ogi_pkg::CFG_DATA_W-1:0] cfg_data,
  ogi_cmd_if.sink                        cmd,
  ogi_res_if.source                      res
);
  import ogi_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR,
    S_HZ_RD, S_HZ_LOAD, S_HZ_RUN, S_HZ_WR,
    S_VT_PRE, S_VT_RUN, S_VT_DRAIN,
    S_CQ_RD, S_CQ_EV,
    S_BQ_MUL, S_BQ_MASK, S_BQ_RUN, S_BQ_DRAIN,
    S_RESULT
  } state_t;

  // Configuration
  logic [SIZE_W-1:0]   map_width;
  logic [SIZE_W-1:0]   map_height;
  logic [RADIUS_W-1:0] inflate_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width      <= RST_MAP_WIDTH;
      map_height     <= RST_MAP_HEIGHT;
      inflate_radius <= RST_INFLATE_RADIUS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_WIDTH:      map_width      <= cfg_data[SIZE_W-1:0];
        CFG_MAP_HEIGHT:     map_height     <= cfg_data[SIZE_W-1:0];
        CFG_INFLATE_RADIUS: inflate_radius <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Size in use and column mask
  logic [SIZE_W-1:0]    eff_w;
  logic [SIZE_W-1:0]    eff_h;
  logic [MAX_WIDTH-1:0] wmask;

  assign eff_w = (map_width  > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : map_width;
  assign eff_h = (map_height > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : map_height;

  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      wmask[c] = (SIZE_W'(c) < eff_w);
    end
  end

  // Sequencer registers
  state_t               state;
  logic [ROW_W-1:0]     rowc;
  logic [RADIUS_W-1:0]  step;
  logic [BS_W-1:0]      bj;
  logic [COORD_W-1:0]   px;
  logic [COORD_W-1:0]   py;
  logic                 pix_obs;
  logic [BS_W-1:0]      bsz;
  logic [BLK_W-1:0]     x0;
  logic [BLK_W-1:0]     y0;
  logic [MAX_WIDTH-1:0] bmask;
  logic [MAX_WIDTH-1:0] fw;
  logic [MAX_WIDTH-1:0] bw;
  logic                 acc;
  logic                 pend;
  logic                 occ_r;
  vstep_t               vs;
  vstep_t               vs_next;
  logic                 res_valid;
  logic                 res_occ;
  logic                 res_load;

  // Memory ports
  logic                 a_we;
  logic [ROW_W-1:0]     a_wa;
  logic [MAX_WIDTH-1:0] a_wd;
  logic [ROW_W-1:0]     a_ra;
  logic [MAX_WIDTH-1:0] a_rd;
  logic                 b_we_infl;
  logic                 b_we_hp;
  logic [ROW_W-1:0]     b_wa;
  logic [MAX_WIDTH-1:0] b_wd_infl;
  logic [MAX_WIDTH-1:0] b_wd_hp;
  logic [ROW_W-1:0]     b_ra0;
  logic [ROW_W-1:0]     b_ra1;
  logic [MAX_WIDTH-1:0] b_rd0_infl;
  logic [MAX_WIDTH-1:0] b_rd0_hp;
  logic [MAX_WIDTH-1:0] b_rd1_hp;
  logic [MAX_WIDTH-1:0] cov;

  ogi_orig_mem u_orig_mem (
    .clk (clk),
    .we  (a_we),
    .wa  (a_wa),
    .wd  (a_wd),
    .ra  (a_ra),
    .rd  (a_rd)
  );

  ogi_work_mem u_work_mem (
    .clk      (clk),
    .we_infl  (b_we_infl),
    .we_hp    (b_we_hp),
    .wa       (b_wa),
    .wd_infl  (b_wd_infl),
    .wd_hp    (b_wd_hp),
    .ra0      (b_ra0),
    .ra1      (b_ra1),
    .rd0_infl (b_rd0_infl),
    .rd0_hp   (b_rd0_hp),
    .rd1_hp   (b_rd1_hp)
  );

  logic cmd_acc;
  logic vclear;

  assign cmd_acc = cmd.valid && (state == S_IDLE);
  assign vclear  = cmd_acc && (cmd.action == ACT_INFLATE);

  ogi_vcount u_vcount (
    .clk     (clk),
    .clear   (vclear),
    .step    (vs),
    .add_row (b_rd0_hp),
    .sub_row (b_rd1_hp),
    .cov     (cov)
  );

  // Vertical window rows: row y + r enters, row y - r leaves
  logic [SIZE_W-1:0] vt_add;
  logic [SIZE_W-1:0] vt_sub;
  logic              add_ok;
  logic              sub_ok;
  logic              pre_ok;

  assign vt_add = SIZE_W'(rowc) + SIZE_W'(inflate_radius);
  assign vt_sub = SIZE_W'(rowc) - SIZE_W'(inflate_radius);
  assign add_ok = (vt_add < eff_h);
  assign sub_ok = (SIZE_W'(rowc) >= SIZE_W'(inflate_radius)) && (vt_sub < eff_h);
  assign pre_ok = (SIZE_W'(rowc) < eff_h);

  // Counter step issued with the row reads, applied when the data returns
  always_comb begin
    vs_next = '0;
    if (state == S_VT_PRE) begin
      vs_next.add = pre_ok;
    end else if (state == S_VT_RUN) begin
      vs_next.add = add_ok;
      vs_next.sub = sub_ok;
      vs_next.wr  = 1'b1;
      vs_next.row = rowc;
    end
  end

  // Result register loads when empty or being drained
  assign res_load = (state == S_RESULT) && (!res_valid || res.ready);

  // Block walk
  logic [BLK_W-1:0]     bq_row;
  logic                 bq_row_ok;
  logic                 bq_hit;
  logic [MAX_WIDTH-1:0] bmask_next;

  assign bq_row    = y0 + BLK_W'(bj);
  assign bq_row_ok = (bq_row < BLK_W'(eff_h));
  assign bq_hit    = |(b_rd0_infl & bmask);

  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      bmask_next[c] = (BLK_W'(c) >= x0) && (BLK_W'(c) < x0 + BLK_W'(bsz)) && wmask[c];
    end
  end

  // Single-cell update of a row for a load
  logic [MAX_WIDTH-1:0] a_row_ld;
  logic [MAX_WIDTH-1:0] b_row_ld;

  always_comb begin
    a_row_ld     = a_rd;
    b_row_ld     = b_rd0_infl;
    a_row_ld[px] = pix_obs;
    b_row_ld[px] = pix_obs;
  end

  // Memory addressing and writes
  always_comb begin
    a_we      = 1'b0;
    a_wa      = rowc;
    a_wd      = '0;
    a_ra      = rowc;
    b_we_infl = 1'b0;
    b_we_hp   = 1'b0;
    b_wa      = rowc;
    b_wd_infl = '0;
    b_wd_hp   = '0;
    b_ra0     = rowc;
    b_ra1     = rowc;
    unique case (state)
      S_CLEAR: begin
        a_we      = 1'b1;
        b_we_infl = 1'b1;
        b_we_hp   = 1'b1;
      end
      S_LD_RD: begin
        a_ra  = ROW_W'(py);
        b_ra0 = ROW_W'(py);
      end
      S_LD_WR: begin
        a_we      = 1'b1;
        a_wa      = ROW_W'(py);
        a_wd      = a_row_ld;
        b_we_infl = 1'b1;
        b_wa      = ROW_W'(py);
        b_wd_infl = b_row_ld;
      end
      S_HZ_WR: begin
        b_we_hp = 1'b1;
        b_wd_hp = (inflate_radius == '0) ? '0 : (fw | bw);
      end
      S_VT_RUN: begin
        b_ra0 = vt_add[ROW_W-1:0];
        b_ra1 = vt_sub[ROW_W-1:0];
      end
      S_CQ_RD:  b_ra0 = ROW_W'(py);
      S_BQ_RUN: b_ra0 = bq_row[ROW_W-1:0];
      default: ;
    endcase
    // Vertical pass result: one inflated row a cycle, zero outside the map
    if (vs.wr) begin
      b_we_infl = 1'b1;
      b_wa      = vs.row;
      b_wd_infl = (a_rd | cov) & wmask & {MAX_WIDTH{SIZE_W'(vs.row) < eff_h}};
    end
  end

  state_t vt_entry;
  assign vt_entry = (inflate_radius == '0) ? S_VT_RUN : S_VT_PRE;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rowc      <= '0;
      vs        <= '0;
      res_valid <= 1'b0;
    end else begin
      vs <= vs_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          rowc <= rowc + 1'b1;
          if (rowc == ROW_W'(MAX_HEIGHT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            px      <= cmd.cell_x;
            py      <= cmd.cell_y;
            bsz     <= cmd.block_size;
            pix_obs <= (cmd.red == '0) && (cmd.green == '0) && (cmd.blue == '0);
            occ_r   <= 1'b0;
            rowc    <= '0;
            case (cmd.action)
              ACT_LOAD: begin
                if (SIZE_W'(cmd.cell_x) < eff_w && SIZE_W'(cmd.cell_y) < eff_h) begin
                  state <= S_LD_RD;
                end else begin
                  state <= S_RESULT;
                end
              end
              ACT_INFLATE: begin
                state <= (eff_h != '0) ? S_HZ_RD : vt_entry;
              end
              ACT_QCELL: state <= S_CQ_RD;
              default:   state <= S_BQ_MUL;
            endcase
          end
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: state <= S_RESULT;
        // Horizontal pass: fw grows toward lower columns, bw toward higher
        S_HZ_RD: state <= S_HZ_LOAD;
        S_HZ_LOAD: begin
          fw    <= a_rd & wmask;
          bw    <= a_rd & wmask;
          step  <= RADIUS_W'(1);
          state <= (inflate_radius == '0) ? S_HZ_WR : S_HZ_RUN;
        end
        S_HZ_RUN: begin
          fw <= fw | (fw >> 1);
          if (step != inflate_radius) begin
            bw <= bw | (bw << 1);
          end
          step <= step + 1'b1;
          if (step == inflate_radius) begin
            state <= S_HZ_WR;
          end
        end
        S_HZ_WR: begin
          if (SIZE_W'(rowc) == eff_h - 1'b1) begin
            rowc  <= '0;
            state <= vt_entry;
          end else begin
            rowc  <= rowc + 1'b1;
            state <= S_HZ_RD;
          end
        end
        // Vertical pass: preload rows below r, then slide over every row
        S_VT_PRE: begin
          if (SIZE_W'(rowc) == SIZE_W'(inflate_radius) - 1'b1) begin
            rowc  <= '0;
            state <= S_VT_RUN;
          end else begin
            rowc <= rowc + 1'b1;
          end
        end
        S_VT_RUN: begin
          rowc <= rowc + 1'b1;
          if (rowc == ROW_W'(MAX_HEIGHT - 1)) begin
            state <= S_VT_DRAIN;
          end
        end
        S_VT_DRAIN: state <= S_RESULT;
        S_CQ_RD:    state <= S_CQ_EV;
        S_CQ_EV: begin
          occ_r <= (SIZE_W'(px) < eff_w) && (SIZE_W'(py) < eff_h) && b_rd0_infl[px];
          state <= S_RESULT;
        end
        S_BQ_MUL: begin
          x0    <= BLK_W'(px) * BLK_W'(bsz);
          y0    <= BLK_W'(py) * BLK_W'(bsz);
          state <= (bsz == '0) ? S_RESULT : S_BQ_MASK;
        end
        S_BQ_MASK: begin
          bmask <= bmask_next;
          bj    <= '0;
          acc   <= 1'b0;
          pend  <= 1'b0;
          state <= S_BQ_RUN;
        end
        S_BQ_RUN: begin
          pend <= bq_row_ok;
          acc  <= acc | (pend & bq_hit);
          bj   <= bj + 1'b1;
          if (bj == bsz - 1'b1) begin
            state <= S_BQ_DRAIN;
          end
        end
        S_BQ_DRAIN: begin
          occ_r <= acc | (pend & bq_hit);
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (res_load) begin
            res_occ <= occ_r;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready    = (state == S_IDLE);
  assign res.valid    = res_valid;
  assign res.occupied = res_occ;
  assign res.done_res = 1'b1;

endmodule

### hw/rtl/ogi_orig_mem.sv
// Original obstacle map: one row of cells per word, one write and one read port
module ogi_orig_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ogi_pkg::ROW_W-1:0]     wa,
  input  logic [ogi_pkg::MAX_WIDTH-1:0] wd,
  input  logic [ogi_pkg::ROW_W-1:0]     ra,
  output logic [ogi_pkg::MAX_WIDTH-1:0] rd
);
  import ogi_pkg::*;

  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

### hw/rtl/ogi_work_mem.sv
// Working map: each row word holds the inflated row (low half) and the
// horizontal pass row (high half); halves are written separately.
module ogi_work_mem (
  input  logic                          clk,
  input  logic                          we_infl,
  input  logic                          we_hp,
  input  logic [ogi_pkg::ROW_W-1:0]     wa,
  input  logic [ogi_pkg::MAX_WIDTH-1:0] wd_infl,
  input  logic [ogi_pkg::MAX_WIDTH-1:0] wd_hp,
  input  logic [ogi_pkg::ROW_W-1:0]     ra0,
  input  logic [ogi_pkg::ROW_W-1:0]     ra1,
  output logic [ogi_pkg::MAX_WIDTH-1:0] rd0_infl,
  output logic [ogi_pkg::MAX_WIDTH-1:0] rd0_hp,
  output logic [ogi_pkg::MAX_WIDTH-1:0] rd1_hp
);
  import ogi_pkg::*;

  logic [2*MAX_WIDTH-1:0] mem [MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (we_infl) begin
      mem[wa][MAX_WIDTH-1:0] <= wd_infl;
    end
    if (we_hp) begin
      mem[wa][2*MAX_WIDTH-1:MAX_WIDTH] <= wd_hp;
    end
    {rd0_hp, rd0_infl} <= mem[ra0];
    rd1_hp             <= mem[ra1][2*MAX_WIDTH-1:MAX_WIDTH];
  end

endmodule

### hw/rtl/ogi_vcount.sv
// Per-column counters of marked rows inside the vertical window.
// A column is covered when its count after this step is nonzero.
module ogi_vcount (
  input  logic                          clk,
  input  logic                          clear,
  input  ogi_pkg::vstep_t               step,
  input  logic [ogi_pkg::MAX_WIDTH-1:0] add_row,
  input  logic [ogi_pkg::MAX_WIDTH-1:0] sub_row,
  output logic [ogi_pkg::MAX_WIDTH-1:0] cov
);
  import ogi_pkg::*;

  logic [CNT_W-1:0] cnt      [MAX_WIDTH];
  logic [CNT_W-1:0] cnt_next [MAX_WIDTH];

  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      cnt_next[c] = cnt[c] + CNT_W'(step.add & add_row[c]) - CNT_W'(step.sub & sub_row[c]);
      cov[c]      = (cnt_next[c] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      cnt <= '{default: '0};
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

### hw/rtl/ogi_checker.sv
module ogi_checker (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready,
  input logic occupied,
  input logic done_res
);

  // A stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(occupied))
    else $error("result beat changed while stalled");

  // Reset starts the clearing pass, so no command is taken right after
  a_rst_busy: assert property (@(posedge clk)
    rst |=> !cmd_ready)
    else $error("command ready right after reset");

  // One item at a time: busy after a command beat
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while an item is in work");

  // A new result only comes out of a busy cycle
  a_res_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(cmd_ready))
    else $error("result raised straight from idle");

  // Every result reports completion
  a_done: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> done_res)
    else $error("result without done flag");

endmodule

bind occupancy_grid_obstacle_inflate ogi_checker u_ogi_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .occupied  (res.occupied),
  .done_res  (res.done_res)
);
